// ===== hw/rtl/astm_frame_encoder_macros.svh =====
// Assertion macros used by the frame encoder queue.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ASTM_FRAME_ENCODER_MACROS_SVH
`define ASTM_FRAME_ENCODER_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define AFE_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("frame encoder check failed");

// Check that a trigger is followed in the next cycle by a consequence.
`define AFE_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("frame encoder sequence check failed");

`endif

// ===== hw/rtl/afe_pkg.sv =====
// Package of the ASTM frame encoder: opcodes, framing characters, frame command type.
// No dependencies; used by every module of the encoder.
package afe_pkg;

   localparam int FRAME_DATA_MAX = 240;
   localparam int FRAME_CAP_INT  = (FRAME_DATA_MAX < 2) ? 2 :
                                   ((FRAME_DATA_MAX > 255) ? 255 : FRAME_DATA_MAX);
   localparam logic [7:0] FRAME_CAP = 8'(FRAME_CAP_INT);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_STX  = 8'h02;
   localparam logic [7:0] CH_ETX  = 8'h03;
   localparam logic [7:0] CH_ETB  = 8'h17;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;

   typedef enum logic [1:0] {
      OP_DATA = 2'd0,
      OP_EOR  = 2'd1,
      OP_SOM  = 2'd2
   } opcode_type;

   // One command per input item that yields bytes.
   typedef struct packed {
      logic       open;      // emit STX and frame digit first
      logic       has_data;  // emit the data byte
      logic       close;     // emit the trailer
      logic       term_etx;  // trailer ends in ETX, else ETB
      logic [2:0] digit;     // frame number
      logic [7:0] data;      // data byte
      logic [7:0] sum;       // checksum of the frame so far; final when close is set
   } cmd_type;

   typedef enum logic [3:0] {
      STEP_STX,
      STEP_DIGIT,
      STEP_DATA,
      STEP_CR1,
      STEP_TERM,
      STEP_HEXHI,
      STEP_HEXLO,
      STEP_CR2,
      STEP_LF
   } step_type;

endpackage

// ===== hw/rtl/afe_front.sv =====
// Front end of the frame encoder: accepts input transactions, tracks frame state,
// and issues frame commands. Depends on afe_pkg.
module afe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [7:0]           req_data_byte,
   output logic                 push_valid,
   output afe_pkg::cmd_type     push_cmd,
   input  logic                 push_ready
);

   logic [2:0] frame_number_ff, frame_number_in;
   logic [7:0] bytes_ff, bytes_in;
   logic [7:0] sum_ff, sum_in;
   logic       open_ff, open_in;

   logic       accept;
   logic       need_open;
   logic [7:0] base_sum;
   logic [7:0] data_sum;
   logic [7:0] count_next;
   logic       full;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      need_open  = !open_ff;
      base_sum   = need_open ? (afe_pkg::CH_ZERO + {5'd0, frame_number_ff}) : sum_ff;
      data_sum   = base_sum + req_data_byte;
      count_next = (need_open ? 8'd0 : bytes_ff) + 8'd1;
      full       = (count_next >= afe_pkg::FRAME_CAP);

      frame_number_in = frame_number_ff;
      bytes_in        = bytes_ff;
      sum_in          = sum_ff;
      open_in         = open_ff;
      push_valid      = 1'b0;

      push_cmd.open     = need_open;
      push_cmd.has_data = 1'b0;
      push_cmd.close    = 1'b0;
      push_cmd.term_etx = 1'b0;
      push_cmd.digit    = frame_number_ff;
      push_cmd.data     = req_data_byte;
      push_cmd.sum      = data_sum;

      case (req_opcode)
         afe_pkg::OP_DATA: begin
            push_valid        = accept;
            push_cmd.has_data = 1'b1;
            if (full) begin
               push_cmd.close = 1'b1;
               push_cmd.sum   = data_sum + afe_pkg::CH_CR + afe_pkg::CH_ETB;
            end
            if (accept) begin
               if (full) begin
                  frame_number_in = frame_number_ff + 3'd1;
                  bytes_in        = 8'd0;
                  sum_in          = 8'd0;
                  open_in         = 1'b0;
               end else begin
                  bytes_in = count_next;
                  sum_in   = data_sum;
                  open_in  = 1'b1;
               end
            end
         end
         afe_pkg::OP_EOR: begin
            push_valid        = accept;
            push_cmd.close    = 1'b1;
            push_cmd.term_etx = 1'b1;
            push_cmd.sum      = base_sum + afe_pkg::CH_CR + afe_pkg::CH_ETX;
            if (accept) begin
               frame_number_in = frame_number_ff + 3'd1;
               bytes_in        = 8'd0;
               sum_in          = 8'd0;
               open_in         = 1'b0;
            end
         end
         afe_pkg::OP_SOM: begin
            if (accept) begin
               frame_number_in = 3'd1;
               bytes_in        = 8'd0;
               sum_in          = 8'd0;
               open_in         = 1'b0;
            end
         end
         default: begin
            // drop unused opcode
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_number_ff <= 3'd1;
         bytes_ff        <= 8'd0;
         sum_ff          <= 8'd0;
         open_ff         <= 1'b0;
      end else begin
         frame_number_ff <= frame_number_in;
         bytes_ff        <= bytes_in;
         sum_ff          <= sum_in;
         open_ff         <= open_in;
      end
   end

endmodule

// ===== hw/rtl/afe_queue.sv =====
// Command queue between front and back end of the frame encoder.
// Depends on afe_pkg and astm_frame_encoder_macros.svh.
`include "astm_frame_encoder_macros.svh"

module afe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  afe_pkg::cmd_type  push_cmd,
   output logic              push_ready,
   output logic              head_valid,
   output afe_pkg::cmd_type  head_cmd,
   input  logic              pop
);

   afe_pkg::cmd_type slot_ff [afe_pkg::QUEUE_DEPTH];
   logic [afe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [afe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [afe_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != afe_pkg::QCNT_W'(afe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? afe_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? afe_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `AFE_ASSERT(a_count_bound, count_ff <= afe_pkg::QCNT_W'(afe_pkg::QUEUE_DEPTH))
   `AFE_ASSERT(a_ptr_track, afe_pkg::QPTR_W'(wr_ptr_ff - rd_ptr_ff) == afe_pkg::QPTR_W'(count_ff))
   `AFE_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)
   `AFE_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1)

endmodule

// ===== hw/rtl/afe_back.sv =====
// Back end of the frame encoder: expands frame commands into framed bytes and
// drives the registered result channel. Depends on afe_pkg.
module afe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  afe_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last
);

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
   endfunction

   logic               busy_ff, busy_in;
   afe_pkg::step_type  step_ff, step_in;
   afe_pkg::cmd_type   cmd_ff, cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   afe_pkg::cmd_type   act;
   afe_pkg::step_type  cur;
   afe_pkg::step_type  nxt;
   logic               act_valid;
   logic               done;
   logic [7:0]         byte_val;
   logic               out_ok;
   logic               fire;

   always_comb begin
      act       = busy_ff ? cmd_ff : head_cmd;
      act_valid = busy_ff || head_valid;

      if (busy_ff) begin
         cur = step_ff;
      end else if (head_cmd.open) begin
         cur = afe_pkg::STEP_STX;
      end else if (head_cmd.has_data) begin
         cur = afe_pkg::STEP_DATA;
      end else begin
         cur = afe_pkg::STEP_CR1;
      end

      nxt      = afe_pkg::STEP_STX;
      done     = 1'b0;
      byte_val = afe_pkg::CH_LF;
      case (cur)
         afe_pkg::STEP_STX: begin
            byte_val = afe_pkg::CH_STX;
            nxt      = afe_pkg::STEP_DIGIT;
         end
         afe_pkg::STEP_DIGIT: begin
            byte_val = afe_pkg::CH_ZERO + {5'd0, act.digit};
            nxt      = act.has_data ? afe_pkg::STEP_DATA : afe_pkg::STEP_CR1;
         end
         afe_pkg::STEP_DATA: begin
            byte_val = act.data;
            nxt      = afe_pkg::STEP_CR1;
            done     = !act.close;
         end
         afe_pkg::STEP_CR1: begin
            byte_val = afe_pkg::CH_CR;
            nxt      = afe_pkg::STEP_TERM;
         end
         afe_pkg::STEP_TERM: begin
            byte_val = act.term_etx ? afe_pkg::CH_ETX : afe_pkg::CH_ETB;
            nxt      = afe_pkg::STEP_HEXHI;
         end
         afe_pkg::STEP_HEXHI: begin
            byte_val = hex_char(act.sum[7:4]);
            nxt      = afe_pkg::STEP_HEXLO;
         end
         afe_pkg::STEP_HEXLO: begin
            byte_val = hex_char(act.sum[3:0]);
            nxt      = afe_pkg::STEP_CR2;
         end
         afe_pkg::STEP_CR2: begin
            byte_val = afe_pkg::CH_CR;
            nxt      = afe_pkg::STEP_LF;
         end
         afe_pkg::STEP_LF: begin
            byte_val = afe_pkg::CH_LF;
            done     = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase

      out_ok = !rsp_valid_ff || rsp_ready;
      fire   = out_ok && act_valid;
      pop    = fire && !busy_ff;

      busy_in = fire ? !done : busy_ff;
      step_in = (fire && !done) ? nxt : step_ff;
      cmd_in  = pop ? head_cmd : cmd_ff;

      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in  = fire ? byte_val : rsp_byte_ff;
      rsp_last_in  = fire ? done : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= afe_pkg::STEP_STX;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== hw/rtl/astm_frame_encoder.sv =====
// Top level of the ASTM style frame encoder: front end, command queue, back end.
// Depends on afe_pkg, afe_front, afe_queue and afe_back.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_opcode[1:0], req_data_byte[7:0]
//  rsp      out  rsp_valid/rsp_ready    rsp_out_byte[7:0], rsp_last
//
// The front end takes one input transaction per cycle while the four entry
// command queue has room. The back end sends one byte per cycle while the
// result channel takes it: one for a data byte, two more for an opening, six for
// a trailer. Start of message and unused opcodes yield no bytes.
// Reset is synchronous and active high; it empties the queue and returns the
// frame state to frame number 1 with no frame open.
// A stalled result channel holds the output register; input stalls once the
// queue fills.
module astm_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   // front end to queue
   logic              push_valid;
   logic              push_ready;
   afe_pkg::cmd_type  push_cmd;

   // queue to back end
   logic              head_valid;
   afe_pkg::cmd_type  head_cmd;
   logic              pop;

   // Classify each transaction and keep the running frame state.
   afe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .push_ready    (push_ready)
   );

   // Decouple the two sides so each can stall on its own.
   afe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   // Expand commands into the framed byte stream.
   afe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== bench/tb_astm_frame_encoder.sv =====
// Self-checking bench for astm_frame_encoder: framed byte stream vs. a local frame predictor.
// Depends on afe_pkg for opcodes, framing characters and the frame capacity.
`timescale 1ns / 1ps

module tb_astm_frame_encoder;
   import afe_pkg::*;

   // Unused opcode: the block must ignore it completely.
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // A full frame alone takes FRAME_CAP_INT data items; keep the random part short.
   localparam int RANDOM_ITEMS   = 40;
   localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
   localparam int QUIET_ITEMS    = 20;    // no idling for the last items
   localparam int TAIL_CYCLES    = 30;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data;
   } stim_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } framed_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = OP_SOM;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   stim_item_type   pending_items[$];
   framed_byte_type expected_bytes[$];

   // Predictor state of the framer.
   logic [2:0] frame_num  = 3'd1;
   logic [7:0] frame_len  = 8'd0;
   logic [7:0] frame_sum  = 8'd0;
   logic       frame_live = 1'b0;
   logic [7:0] burst_bytes [0:7];
   int         burst_len;

   // Handshake and run bookkeeping of the clocked processes.
   logic req_taken      = 1'b0;
   logic quiet_tail     = 1'b0;
   logic stall_request  = 1'b0;
   logic long_hold_done = 1'b0;
   int   drain_index    = 0;
   int   sent_count     = 0;
   int   send_gap       = 0;
   int   ready_gap      = 0;
   int   hold_count     = 0;
   int   idle_cycles    = 0;
   int   mismatch_count = 0;

   astm_frame_encoder uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Frame predictor: turns one accepted transaction into its byte burst.
   // ------------------------------------------------------------------
   function automatic logic [7:0] hex_ascii(input logic [3:0] nibble);
      return (nibble < 4'd10) ? CH_ZERO + 8'(nibble) : CH_UPPER_A + 8'(nibble) - 8'd10;
   endfunction

   task automatic put_char(input logic [7:0] ch, input bit summed);
      burst_bytes[burst_len] = ch;
      burst_len = burst_len + 1;
      if (summed) frame_sum = frame_sum + ch;
   endtask

   task automatic open_frame();
      put_char(CH_STX, 1'b0);
      frame_sum = 8'd0;
      put_char(CH_ZERO + {5'd0, frame_num}, 1'b1);
      frame_len  = 8'd0;
      frame_live = 1'b1;
   endtask

   task automatic close_frame(input logic [7:0] terminator);
      // The CR ahead of the terminator counts in the checksum.
      put_char(CH_CR, 1'b1);
      put_char(terminator, 1'b1);
      put_char(hex_ascii(frame_sum[7:4]), 1'b0);
      put_char(hex_ascii(frame_sum[3:0]), 1'b0);
      put_char(CH_CR, 1'b0);
      put_char(CH_LF, 1'b0);
      frame_num  = frame_num + 3'd1;
      frame_len  = 8'd0;
      frame_sum  = 8'd0;
      frame_live = 1'b0;
   endtask

   task automatic encode_item(input logic [1:0] op, input logic [7:0] data);
      framed_byte_type fb;
      burst_len = 0;
      case (op)
         OP_DATA: begin
            if (!frame_live) open_frame();
            put_char(data, 1'b1);
            frame_len = frame_len + 8'd1;
            if (frame_len >= FRAME_CAP) close_frame(CH_ETB);
         end
         OP_EOR: begin
            // An end of record with no open frame still yields an empty frame.
            if (!frame_live) open_frame();
            close_frame(CH_ETX);
         end
         OP_SOM: begin
            // Drop any open frame without a trailer.
            frame_num  = 3'd1;
            frame_len  = 8'd0;
            frame_sum  = 8'd0;
            frame_live = 1'b0;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < burst_len; i++) begin
         fb.ch   = burst_bytes[i];
         fb.last = (i == burst_len - 1);
         expected_bytes.push_back(fb);
      end
   endtask

   task automatic report_mismatch(input string what, input framed_byte_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $time, what, want.ch, want.last, rsp_out_byte, rsp_last);
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Check the outgoing
   // transaction first, then predict from the incoming one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      framed_byte_type want;
      if (reset) begin
         req_taken  <= 1'b0;
         frame_num  = 3'd1;
         frame_len  = 8'd0;
         frame_sum  = 8'd0;
         frame_live = 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               want = '0;
               report_mismatch("unexpected result", want);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.ch || rsp_last !== want.last)
                  report_mismatch("result mismatch", want);
            end
         end
         if (req_valid && req_ready) encode_item(req_opcode, req_data_byte);
      end
   end

   // ------------------------------------------------------------------
   // Driver: change inputs at the falling edge. Hold valid and payload until
   // the transaction was taken at the previous rising edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      stim_item_type nxt;
      int gap;
      bit long_hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         long_hold = stall_request && !long_hold_done;
         quiet_tail <= (pending_items.size() < QUIET_ITEMS);
         // Start an idle burst now and then, but keep offering while the
         // receiver is in its long hold-off so the queue fills up.
         if (req_valid && !quiet_tail && !long_hold && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 12);
         else
            gap = send_gap;
         if (gap > 0) begin
            req_valid <= 1'b0;
            send_gap = gap - 1;
         end else if (pending_items.size() != 0 &&
                      !(sent_count == drain_index && expected_bytes.size() != 0)) begin
            // At the drain point, hold back until every result is in.
            nxt = pending_items.pop_front();
            req_valid     <= 1'b1;
            req_opcode    <= nxt.opcode;
            req_data_byte <= nxt.data;
            sent_count = sent_count + 1;
            if (sent_count == drain_index + 20) stall_request <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off, none in the tail.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_request && !long_hold_done) begin
         rsp_ready <= 1'b0;
         if (hold_count == LONG_HOLD) long_hold_done <= 1'b1;
         else hold_count = hold_count + 1;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap = ready_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         ready_gap = $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_astm_frame_encoder: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   task automatic queue_item(input logic [1:0] op, input logic [7:0] data);
      stim_item_type it;
      it.opcode = op;
      it.data   = data;
      pending_items.push_back(it);
   endtask

   initial begin
      int random_items;
      int rec_len;

      // Directed: empty record at reset, field extremes, zero byte,
      // ignored opcode inside and outside a frame, message start mid-frame.
      queue_item(OP_EOR, 8'h00);
      queue_item(OP_DATA, 8'h00);
      queue_item(OP_DATA, 8'hFF);
      queue_item(OP_DATA, 8'h01);
      queue_item(OP_DATA, 8'h80);
      queue_item(OP_DATA, 8'h55);
      queue_item(OP_DATA, 8'hAA);
      queue_item(OP_EOR, 8'hFF);
      queue_item(OP_UNUSED, 8'hFF);
      queue_item(OP_DATA, 8'h41);
      queue_item(OP_UNUSED, 8'h00);
      queue_item(OP_DATA, 8'h42);
      queue_item(OP_EOR, 8'h00);
      queue_item(OP_DATA, 8'h7F);
      queue_item(OP_SOM, 8'hFF);
      queue_item(OP_DATA, 8'h10);
      queue_item(OP_EOR, 8'h00);
      queue_item(OP_SOM, 8'h00);
      queue_item(OP_EOR, 8'h00);
      drain_index = pending_items.size();

      // A record that exactly fills a frame: ETB frame, then an empty ETX frame.
      for (int i = 0; i < FRAME_CAP_INT; i++) queue_item(OP_DATA, 8'($urandom_range(0, 255)));
      queue_item(OP_EOR, 8'($urandom_range(0, 255)));

      // Random records with a little noise: stray message starts and unused opcodes.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         rec_len = $urandom_range(0, 9);
         for (int i = 0; i < rec_len; i++) begin
            queue_item(OP_DATA, 8'($urandom_range(0, 255)));
            random_items++;
            if ($urandom_range(0, 24) == 0)
               queue_item(($urandom_range(0, 1) == 0) ? OP_SOM : OP_UNUSED,
                          8'($urandom_range(0, 255)));
         end
         queue_item(OP_EOR, 8'($urandom_range(0, 255)));
         random_items++;
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Drain: everything offered, everything taken, every result seen.
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_bytes.size() != 0) begin
         mismatch_count = mismatch_count + expected_bytes.size();
         $display("%0d expected results never arrived", expected_bytes.size());
      end
      if (mismatch_count == 0) begin
         $display("tb_astm_frame_encoder: PASS");
      end else begin
         $display("tb_astm_frame_encoder: FAIL");
      end
      $finish;
   end

endmodule
